/* hdl/dppm_pkg.sv */
// Shared types and constants for the delay pair to pixel mapper.
// Used by the square root cell and the top level; depends on nothing.
package dppm_pkg;

  typedef struct packed {
    logic       loud_enough;
    logic [3:0] delay_horizontal;
    logic [3:0] delay_vertical;
  } in_item_t;

  typedef struct packed {
    logic       loud_flag;
    logic       mark_valid;
    logic [9:0] mark_column;
    logic [8:0] mark_row;
  } out_item_t;

  typedef enum logic [1:0] {
    CFG_DELAY_OFFSET     = 2'd0,
    CFG_SINE_PER_TICK    = 2'd1,
    CFG_SLOPE_HORIZONTAL = 2'd2,
    CFG_SLOPE_VERTICAL   = 2'd3
  } cfg_index_t;

  localparam logic [3:0]  DELAY_OFFSET_RST     = 4'd5;
  localparam logic [15:0] SINE_PER_TICK_RST    = 16'd4642;
  localparam logic [15:0] SLOPE_HORIZONTAL_RST = 16'd24982;
  localparam logic [15:0] SLOPE_VERTICAL_RST   = 16'd18344;

  // Q4.16 slope limit
  localparam logic [19:0] T_LIMIT = 20'hFFFFF;

  // Square root state: partial remainder, partial root, radicand bits left
  typedef struct packed {
    logic [17:0] rem;
    logic [16:0] root;
    logic [33:0] rad;
  } sqrt_state_t;

endpackage

/* hdl/dppm_sqrt_cell.sv */
// One digit step of the pipelined integer square root, plus its register.
// Depends on dppm_pkg for the state struct.
module dppm_sqrt_cell #(
  parameter int TAG_W = 1
) (
  input  logic                      clk,
  input  logic                      en,
  input  dppm_pkg::sqrt_state_t     d,
  input  logic [TAG_W-1:0]          tag_d,
  output dppm_pkg::sqrt_state_t     q,
  output logic [TAG_W-1:0]          tag_q
);

  logic [19:0] r2;
  logic [19:0] trial;
  logic        fits;

  assign r2    = {d.rem, d.rad[33:32]};
  assign trial = {1'b0, d.root, 2'b01};
  assign fits  = (r2 >= trial);

  always_ff @(posedge clk) begin
    if (en) begin
      q.rem  <= fits ? 18'(r2 - trial) : 18'(r2);
      q.root <= {d.root[15:0], fits};
      q.rad  <= {d.rad[31:0], 2'b00};
      tag_q  <= tag_d;
    end
  end

endmodule

/* hdl/dppm_div_cell.sv */
// One restoring division step (one quotient bit), plus its register.
// Standalone; shared by the slope and pixel mapping chains.
module dppm_div_cell #(
  parameter int DIV_W  = 17,
  parameter int NUM_W  = 20,
  parameter int QUOT_W = 20,
  parameter int TAG_W  = 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic [DIV_W-1:0]  rem_d,
  input  logic [NUM_W-1:0]  num_d,
  input  logic [QUOT_W-1:0] quot_d,
  input  logic [DIV_W-1:0]  div_d,
  input  logic [TAG_W-1:0]  tag_d,
  output logic [DIV_W-1:0]  rem_q,
  output logic [NUM_W-1:0]  num_q,
  output logic [QUOT_W-1:0] quot_q,
  output logic [DIV_W-1:0]  div_q,
  output logic [TAG_W-1:0]  tag_q
);

  logic [DIV_W:0] r2;
  logic [DIV_W:0] diff;
  logic           fits;

  assign r2   = {rem_d, num_d[NUM_W-1]};
  assign diff = r2 - {1'b0, div_d};
  assign fits = (r2 >= {1'b0, div_d});

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q  <= fits ? diff[DIV_W-1:0] : r2[DIV_W-1:0];
      num_q  <= num_d << 1;
      quot_q <= {quot_d[QUOT_W-2:0], fits};
      div_q  <= div_d;
      tag_q  <= tag_d;
    end
  end

endmodule

/* hdl/delay_pair_to_pixel_mapper_top.sv */
// Throughput: one item per cycle while the output accepts; every stage holds one item and moves it on
// when the stage after it is free, so bubbles close up under output stall.
// The square root takes 17 cells, the slope divide 20, the pixel divide one per
// quotient bit. Reset empties the pipeline and loads the register defaults.
module delay_pair_to_pixel_mapper_top #(
  parameter int IMAGE_COLUMNS = 640,
  parameter int IMAGE_ROWS    = 480,
  parameter int DELAY_BITS    = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  dppm_pkg::in_item_t   item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output dppm_pkg::out_item_t  result,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int COL_W  = $clog2(IMAGE_COLUMNS + 1);
  localparam int ROW_W  = $clog2(IMAGE_ROWS + 1);
  localparam int QB     = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int NP_W   = 21 + QB;
  localparam int PROD_W = DELAY_BITS + 18;

  localparam int SQRT_CELLS  = 17;
  localparam int SLOPE_CELLS = 20;
  localparam int ST_SINE   = 0;
  localparam int ST_SQUARE = 1;
  localparam int ST_RAD    = 2;
  localparam int ST_SQRT0  = 3;
  localparam int ST_DINIT  = ST_SQRT0 + SQRT_CELLS;
  localparam int ST_DIV0   = ST_DINIT + 1;
  localparam int ST_SLOPE  = ST_DIV0 + SLOPE_CELLS;
  localparam int ST_MINIT  = ST_SLOPE + 1;
  localparam int ST_MAP0   = ST_MINIT + 1;
  localparam int ST_OUT    = ST_MAP0 + QB;
  localparam int NSTG      = ST_OUT + 1;
  localparam int SQ_TAG_W  = 38;

  localparam logic signed [PROD_W-1:0] SINE_HI = PROD_W'(65536);
  localparam logic signed [PROD_W-1:0] SINE_LO = -PROD_W'(65536);

  // ---------------- configuration ----------------
  logic [3:0]  delay_offset;
  logic [15:0] sine_per_tick;
  logic [15:0] slope_horizontal;
  logic [15:0] slope_vertical;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_offset     <= dppm_pkg::DELAY_OFFSET_RST;
      sine_per_tick    <= dppm_pkg::SINE_PER_TICK_RST;
      slope_horizontal <= dppm_pkg::SLOPE_HORIZONTAL_RST;
      slope_vertical   <= dppm_pkg::SLOPE_VERTICAL_RST;
    end else if (cfg_write) begin
      case (dppm_pkg::cfg_index_t'(cfg_index))
        dppm_pkg::CFG_DELAY_OFFSET:     delay_offset     <= cfg_data[3:0];
        dppm_pkg::CFG_SINE_PER_TICK:    sine_per_tick    <= cfg_data;
        dppm_pkg::CFG_SLOPE_HORIZONTAL: slope_horizontal <= cfg_data;
        dppm_pkg::CFG_SLOPE_VERTICAL:   slope_vertical   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline flow control ----------------
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  // a stage advances unless it and every stage after it is full and the output stalls
  for (genvar i = 0; i < NSTG; i++) begin : g_en
    assign en[i] = result_ready || !(&vld[NSTG-1:i]);
  end

  assign item_ready   = en[0];
  assign result_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= item_valid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // ---------------- helpers ----------------
  function automatic logic signed [17:0] clip_sine(input logic signed [PROD_W-1:0] p);
    logic signed [17:0] r;
    if (p > SINE_HI)      r = 18'sd65536;
    else if (p < SINE_LO) r = -18'sd65536;
    else                  r = 18'(p);
    return r;
  endfunction

  function automatic logic [16:0] mag17(input logic signed [17:0] s);
    logic [17:0] n;
    n = -s;
    return s[17] ? n[16:0] : s[16:0];
  endfunction

  // ---------------- sine stage ----------------
  logic [DELAY_BITS-1:0]        dh, dv, doff;
  logic signed [DELAY_BITS:0]   diff_h, diff_v;
  logic signed [PROD_W-1:0]     prod_h, prod_v;
  logic                         s1_loud;
  logic signed [17:0]           s1_sa, s1_sb;

  assign dh     = DELAY_BITS'(item.delay_horizontal);
  assign dv     = DELAY_BITS'(item.delay_vertical);
  assign doff   = DELAY_BITS'(delay_offset);
  assign diff_h = $signed({1'b0, dh}) - $signed({1'b0, doff});
  assign diff_v = $signed({1'b0, dv}) - $signed({1'b0, doff});
  assign prod_h = PROD_W'(diff_h) * PROD_W'($signed({1'b0, sine_per_tick}));
  assign prod_v = PROD_W'(diff_v) * PROD_W'($signed({1'b0, sine_per_tick}));

  always_ff @(posedge clk) begin
    if (en[ST_SINE]) begin
      s1_loud <= item.loud_enough;
      s1_sa   <= clip_sine(prod_h);
      s1_sb   <= clip_sine(prod_v);
    end
  end

  // ---------------- square stage ----------------
  logic [16:0]        s1_ma, s1_mb;
  logic [33:0]        sq_a, sq_b;
  logic               s2_loud;
  logic signed [17:0] s2_sa, s2_sb;
  logic [32:0]        s2_sqa, s2_sqb;

  assign s1_ma = mag17(s1_sa);
  assign s1_mb = mag17(s1_sb);
  assign sq_a  = 34'(s1_ma) * 34'(s1_ma);
  assign sq_b  = 34'(s1_mb) * 34'(s1_mb);

  always_ff @(posedge clk) begin
    if (en[ST_SQUARE]) begin
      s2_loud <= s1_loud;
      s2_sa   <= s1_sa;
      s2_sb   <= s1_sb;
      s2_sqa  <= sq_a[32:0];
      s2_sqb  <= sq_b[32:0];
    end
  end

  // ---------------- radicand stage ----------------
  logic signed [34:0] rad;
  logic               s3_loud, s3_radpos;
  logic signed [17:0] s3_sa, s3_sb;
  logic [33:0]        s3_rad;

  assign rad = 35'sh1_0000_0000 - $signed({2'b00, s2_sqa}) - $signed({2'b00, s2_sqb});

  always_ff @(posedge clk) begin
    if (en[ST_RAD]) begin
      s3_loud   <= s2_loud;
      s3_radpos <= !rad[34] && (rad != '0);
      s3_sa     <= s2_sa;
      s3_sb     <= s2_sb;
      s3_rad    <= {1'b0, rad[32:0]};
    end
  end

  // ---------------- square root chain ----------------
  dppm_pkg::sqrt_state_t sq     [0:SQRT_CELLS];
  logic [SQ_TAG_W-1:0]   sq_tag [0:SQRT_CELLS];

  assign sq[0].rem  = '0;
  assign sq[0].root = '0;
  assign sq[0].rad  = s3_rad;
  assign sq_tag[0]  = {s3_loud, s3_radpos, s3_sa, s3_sb};

  for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
    dppm_sqrt_cell #(.TAG_W(SQ_TAG_W)) u_cell (
      .clk   (clk),
      .en    (en[ST_SQRT0 + k]),
      .d     (sq[k]),
      .tag_d (sq_tag[k]),
      .q     (sq[k+1]),
      .tag_q (sq_tag[k+1])
    );
  end

  // ---------------- slope divide init ----------------
  logic               r_loud, r_radpos;
  logic signed [17:0] r_sa, r_sb;
  logic [16:0]        root;
  logic [32:0]        na, nb;

  assign {r_loud, r_radpos, r_sa, r_sb} = sq_tag[SQRT_CELLS];
  assign root = sq[SQRT_CELLS].root;
  assign na   = {mag17(r_sa), 16'h0000};
  assign nb   = {mag17(r_sb), 16'h0000};

  logic [16:0] da_rem  [0:SLOPE_CELLS];
  logic [19:0] da_num  [0:SLOPE_CELLS];
  logic [19:0] da_quot [0:SLOPE_CELLS];
  logic [16:0] da_div  [0:SLOPE_CELLS];
  logic [3:0]  da_tag  [0:SLOPE_CELLS];
  logic [16:0] db_rem  [0:SLOPE_CELLS];
  logic [19:0] db_num  [0:SLOPE_CELLS];
  logic [19:0] db_quot [0:SLOPE_CELLS];
  logic [16:0] db_div  [0:SLOPE_CELLS];
  logic [1:0]  db_tag  [0:SLOPE_CELLS];

  // quotient of 2^20 or more saturates; otherwise the top bits seed the remainder
  always_ff @(posedge clk) begin
    if (en[ST_DINIT]) begin
      da_rem[0]  <= 17'(na[32:20]);
      da_num[0]  <= na[19:0];
      da_quot[0] <= '0;
      da_div[0]  <= root;
      da_tag[0]  <= {r_loud, r_radpos, r_sa[17], (17'(na[32:20]) >= root)};
      db_rem[0]  <= 17'(nb[32:20]);
      db_num[0]  <= nb[19:0];
      db_quot[0] <= '0;
      db_div[0]  <= root;
      db_tag[0]  <= {r_sb[17], (17'(nb[32:20]) >= root)};
    end
  end

  for (genvar k = 0; k < SLOPE_CELLS; k++) begin : g_slope
    dppm_div_cell #(.DIV_W(17), .NUM_W(20), .QUOT_W(20), .TAG_W(4)) u_lane_a (
      .clk(clk), .en(en[ST_DIV0 + k]),
      .rem_d(da_rem[k]), .num_d(da_num[k]), .quot_d(da_quot[k]),
      .div_d(da_div[k]), .tag_d(da_tag[k]),
      .rem_q(da_rem[k+1]), .num_q(da_num[k+1]), .quot_q(da_quot[k+1]),
      .div_q(da_div[k+1]), .tag_q(da_tag[k+1])
    );
    dppm_div_cell #(.DIV_W(17), .NUM_W(20), .QUOT_W(20), .TAG_W(2)) u_lane_b (
      .clk(clk), .en(en[ST_DIV0 + k]),
      .rem_d(db_rem[k]), .num_d(db_num[k]), .quot_d(db_quot[k]),
      .div_d(db_div[k]), .tag_d(db_tag[k]),
      .rem_q(db_rem[k+1]), .num_q(db_num[k+1]), .quot_q(db_quot[k+1]),
      .div_q(db_div[k+1]), .tag_q(db_tag[k+1])
    );
  end

  // ---------------- slope to pixel numerator ----------------
  logic               t_loud, t_radpos, t_sign_a, t_ovf_a, t_sign_b, t_ovf_b;
  logic [19:0]        ta_mag, tb_mag;
  logic signed [20:0] ta, tb;
  logic signed [21:0] sum_h, sum_v;
  logic [NP_W-1:0]    num_h, num_v;
  logic               m1_loud, m1_radpos, m1_neg_h, m1_neg_v;
  logic [NP_W-1:0]    m1_nh, m1_nv;

  assign {t_loud, t_radpos, t_sign_a, t_ovf_a} = da_tag[SLOPE_CELLS];
  assign {t_sign_b, t_ovf_b}                   = db_tag[SLOPE_CELLS];
  assign ta_mag = t_ovf_a ? dppm_pkg::T_LIMIT : da_quot[SLOPE_CELLS];
  assign tb_mag = t_ovf_b ? dppm_pkg::T_LIMIT : db_quot[SLOPE_CELLS];
  assign ta     = t_sign_a ? -$signed({1'b0, ta_mag}) : $signed({1'b0, ta_mag});
  assign tb     = t_sign_b ? -$signed({1'b0, tb_mag}) : $signed({1'b0, tb_mag});
  assign sum_h  = $signed({6'b0, slope_horizontal}) + 22'(ta);
  assign sum_v  = $signed({6'b0, slope_vertical}) - 22'(tb);
  assign num_h  = NP_W'(sum_h[20:0]) * NP_W'(IMAGE_COLUMNS);
  assign num_v  = NP_W'(sum_v[20:0]) * NP_W'(IMAGE_ROWS);

  always_ff @(posedge clk) begin
    if (en[ST_SLOPE]) begin
      m1_loud   <= t_loud;
      m1_radpos <= t_radpos;
      m1_neg_h  <= sum_h[21];
      m1_neg_v  <= sum_v[21];
      m1_nh     <= num_h;
      m1_nv     <= num_v;
    end
  end

  // ---------------- pixel divide init ----------------
  logic [16:0] div_h, div_v;
  logic [20:0] hi_h, hi_v;

  assign div_h = {slope_horizontal, 1'b0};
  assign div_v = {slope_vertical, 1'b0};
  assign hi_h  = m1_nh[NP_W-1:QB];
  assign hi_v  = m1_nv[NP_W-1:QB];

  logic [16:0]   mc_rem  [0:QB];
  logic [QB-1:0] mc_num  [0:QB];
  logic [QB-1:0] mc_quot [0:QB];
  logic [16:0]   mc_div  [0:QB];
  logic [1:0]    mc_tag  [0:QB];
  logic [16:0]   mr_rem  [0:QB];
  logic [QB-1:0] mr_num  [0:QB];
  logic [QB-1:0] mr_quot [0:QB];
  logic [16:0]   mr_div  [0:QB];
  logic          mr_tag  [0:QB];

  // non-positive radicand, negative numerator, zero slope or too large a quotient all map to zero
  always_ff @(posedge clk) begin
    if (en[ST_MINIT]) begin
      mc_rem[0]  <= hi_h[16:0];
      mc_num[0]  <= m1_nh[QB-1:0];
      mc_quot[0] <= '0;
      mc_div[0]  <= div_h;
      mc_tag[0]  <= {m1_loud, !m1_radpos || m1_neg_h || (hi_h >= 21'(div_h))};
      mr_rem[0]  <= hi_v[16:0];
      mr_num[0]  <= m1_nv[QB-1:0];
      mr_quot[0] <= '0;
      mr_div[0]  <= div_v;
      mr_tag[0]  <= !m1_radpos || m1_neg_v || (hi_v >= 21'(div_v));
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_map
    dppm_div_cell #(.DIV_W(17), .NUM_W(QB), .QUOT_W(QB), .TAG_W(2)) u_col (
      .clk(clk), .en(en[ST_MAP0 + k]),
      .rem_d(mc_rem[k]), .num_d(mc_num[k]), .quot_d(mc_quot[k]),
      .div_d(mc_div[k]), .tag_d(mc_tag[k]),
      .rem_q(mc_rem[k+1]), .num_q(mc_num[k+1]), .quot_q(mc_quot[k+1]),
      .div_q(mc_div[k+1]), .tag_q(mc_tag[k+1])
    );
    dppm_div_cell #(.DIV_W(17), .NUM_W(QB), .QUOT_W(QB), .TAG_W(1)) u_row (
      .clk(clk), .en(en[ST_MAP0 + k]),
      .rem_d(mr_rem[k]), .num_d(mr_num[k]), .quot_d(mr_quot[k]),
      .div_d(mr_div[k]), .tag_d(mr_tag[k]),
      .rem_q(mr_rem[k+1]), .num_q(mr_num[k+1]), .quot_q(mr_quot[k+1]),
      .div_q(mr_div[k+1]), .tag_q(mr_tag[k+1])
    );
  end

  // ---------------- output stage ----------------
  logic          f_loud, f_zero_c, f_zero_r, f_valid;
  logic [QB-1:0] col, row, col_m, row_m;

  assign {f_loud, f_zero_c} = mc_tag[QB];
  assign f_zero_r = mr_tag[QB];
  assign col   = (f_zero_c || (mc_quot[QB] > QB'(IMAGE_COLUMNS))) ? '0 : mc_quot[QB];
  assign row   = (f_zero_r || (mr_quot[QB] > QB'(IMAGE_ROWS))) ? '0 : mr_quot[QB];
  assign col_m = QB'(IMAGE_COLUMNS) - col;
  assign row_m = QB'(IMAGE_ROWS) - row;
  assign f_valid = f_loud && (col != '0) && (row != '0);

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      result.loud_flag   <= f_loud;
      result.mark_valid  <= f_valid;
      result.mark_column <= f_valid ? 10'(col_m) : 10'd0;
      result.mark_row    <= f_valid ? 9'(row_m) : 9'd0;
    end
  end

  // ---------------- assertions ----------------
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> (result_valid && !result_ready))
    else $error("input stalled while pipeline had room");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  a_mark_needs_loud: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.mark_valid) |-> (result.loud_flag && $past(vld[ST_OUT-1] || vld[ST_OUT])))
    else $error("mark valid without loud item");

endmodule
